// File: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked outside reset
`define LPMML_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define LPMML_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/lpmml_pkg.sv
package lpmml_pkg;

  localparam int LEN_W  = 16;
  localparam int LOAD_W = 22;
  localparam int PCNT_W = 5;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [APB_AW-1:0] ADDR_PART_COUNT = 3'h0;
  localparam logic [PCNT_W-1:0] PART_COUNT_RST  = 5'd1;

  typedef struct packed {
    logic [PCNT_W-1:0] part_count;
  } cfg_t;

endpackage

// File: sv/lpmml_cfg.sv
module lpmml_cfg
  import lpmml_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [PCNT_W-1:0] part_count_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_count_r <= PART_COUNT_RST;
    end else if (wr_en && paddr == ADDR_PART_COUNT) begin
      part_count_r <= pwdata[PCNT_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_PART_COUNT: prdata = {{(APB_DW-PCNT_W){1'b0}}, part_count_r};
      default:         prdata = '0;
    endcase
  end

  assign cfg.part_count = part_count_r;

endmodule

// File: sv/lpmml_core.sv
module lpmml_core
  import lpmml_pkg::*;
#(
  parameter int MAX_ITEMS = 64,
  parameter int MAX_PARTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              start,
  output logic              busy,
  input  logic [LEN_W-1:0]  in_length_value,
  input  logic              in_is_last,
  output logic              out_valid,
  output logic [LOAD_W-1:0] out_min_max_load
);

  localparam int IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int PART_W = $clog2(MAX_PARTS + 1);
  localparam int COL_D  = 2 ** (IDX_W + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN} state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [LOAD_W-1:0]  sum_r, sum_nxt;
  logic [IDX_W-1:0]   n_last_r, n_last_nxt;
  logic [IDX_W-1:0]   i_r, i_nxt;
  logic [IDX_W-1:0]   l_r, l_nxt;
  logic [PART_W-1:0]  cols_left_r, cols_left_nxt;
  logic               wb_r, wb_nxt;
  logic               first_col_r, first_col_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               rd_first_r, rd_first_nxt;
  logic               rd_lastl_r, rd_lastl_nxt;
  logic [IDX_W-1:0]   rd_row_r, rd_row_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LOAD_W-1:0]  out_load_r, out_load_nxt;

  logic               a_vld_r, a_first_r, a_last_r;
  logic [IDX_W-1:0]   a_row_r;
  logic [LOAD_W-1:0]  cand_r, best_r, ps_i_r;

  logic [LOAD_W-1:0]  ps_mem [MAX_ITEMS];
  logic [LOAD_W-1:0]  col_mem [COL_D];
  logic [LOAD_W-1:0]  ps_rdata_r, col_rdata_r;

  logic [PART_W-1:0]  parts_eff;
  logic               store;
  logic [LOAD_W-1:0]  sum_add, sum_fin;
  logic [CNT_W-1:0]   count_fin;
  logic [LOAD_W-1:0]  ps_i_eff, rest, prev, cand_nxt, best_nxt;
  logic               row_done, fin_emit;

  always_comb begin
    if (cfg.part_count == '0) begin
      parts_eff = PART_W'(1);
    end else if (32'(cfg.part_count) > 32'(MAX_PARTS)) begin
      parts_eff = PART_W'(MAX_PARTS);
    end else begin
      parts_eff = PART_W'(cfg.part_count);
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign store     = start && !busy && count_r < CNT_W'(MAX_ITEMS);
  assign sum_add   = sum_r + LOAD_W'(in_length_value);
  assign sum_fin   = store ? sum_add : sum_r;
  assign count_fin = store ? count_r + CNT_W'(1) : count_r;

  // stage A: candidate max(prev[l], S[i] - S[l]); first read of a row is l = i
  assign ps_i_eff = rd_first_r ? ps_rdata_r : ps_i_r;
  assign rest     = ps_i_eff - ps_rdata_r;
  assign prev     = first_col_r ? ps_rdata_r : col_rdata_r;
  assign cand_nxt = (prev > rest) ? prev : rest;

  // stage B: running minimum over the row
  assign best_nxt = (a_first_r || cand_r < best_r) ? cand_r : best_r;
  assign row_done = a_vld_r && a_last_r;
  assign fin_emit = row_done && cols_left_r == PART_W'(1) && a_row_r == n_last_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    n_last_nxt    = n_last_r;
    i_nxt         = i_r;
    l_nxt         = l_r;
    cols_left_nxt = cols_left_r;
    wb_nxt        = wb_r;
    first_col_nxt = first_col_r;
    rd_vld_nxt    = 1'b0;
    rd_first_nxt  = rd_first_r;
    rd_lastl_nxt  = rd_lastl_r;
    rd_row_nxt    = rd_row_r;
    out_valid_nxt = 1'b0;
    out_load_nxt  = out_load_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          count_nxt = count_fin;
          sum_nxt   = sum_fin;
          if (in_is_last) begin
            count_nxt = '0;
            sum_nxt   = '0;
            if (parts_eff == PART_W'(1)) begin
              out_valid_nxt = 1'b1;
              out_load_nxt  = sum_fin;
            end else begin
              state_nxt     = ST_RUN;
              n_last_nxt    = IDX_W'(count_fin - CNT_W'(1));
              i_nxt         = '0;
              l_nxt         = '0;
              wb_nxt        = 1'b0;
              first_col_nxt = 1'b1;
              cols_left_nxt = parts_eff - PART_W'(1);
            end
          end
        end
      end
      ST_RUN: begin
        rd_vld_nxt   = 1'b1;
        rd_first_nxt = l_r == i_r;
        rd_lastl_nxt = l_r == '0;
        rd_row_nxt   = i_r;
        if (l_r == '0) begin
          if (i_r == n_last_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + IDX_W'(1);
            l_nxt = i_r + IDX_W'(1);
          end
        end else begin
          l_nxt = l_r - IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_r && !a_vld_r) begin
          if (cols_left_r == PART_W'(1)) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt     = ST_RUN;
            cols_left_nxt = cols_left_r - PART_W'(1);
            wb_nxt        = ~wb_r;
            first_col_nxt = 1'b0;
            i_nxt         = '0;
            l_nxt         = '0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (fin_emit) begin
      out_valid_nxt = 1'b1;
      out_load_nxt  = best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_last_r    <= n_last_nxt;
    i_r         <= i_nxt;
    l_r         <= l_nxt;
    cols_left_r <= cols_left_nxt;
    wb_r        <= wb_nxt;
    first_col_r <= first_col_nxt;
    rd_first_r  <= rd_first_nxt;
    rd_lastl_r  <= rd_lastl_nxt;
    rd_row_r    <= rd_row_nxt;
    out_load_r  <= out_load_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= rd_vld_r;
    end
    a_first_r <= rd_first_r;
    a_last_r  <= rd_lastl_r;
    a_row_r   <= rd_row_r;
    cand_r    <= cand_nxt;
    if (rd_vld_r && rd_first_r) begin
      ps_i_r <= ps_rdata_r;
    end
    if (a_vld_r) begin
      best_r <= best_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      ps_mem[count_r[IDX_W-1:0]] <= sum_add;
    end
    ps_rdata_r <= ps_mem[l_r];
  end

  // two column banks; the previous column is read while the current one is written
  always_ff @(posedge clk) begin
    if (row_done) begin
      col_mem[{wb_r, a_row_r}] <= best_nxt;
    end
    col_rdata_r <= col_mem[{~wb_r, l_r}];
  end

  assign out_valid        = out_valid_r;
  assign out_min_max_load = out_load_r;

endmodule

// File: sv/linear_partition_min_max_load.sv
// Load: one beat per cycle; busy stays low while a sequence is loaded.
// Result: with one part, in the cycle after the closing beat. Otherwise after
//   (parts - 1) DP column passes over the sequence, one DP compare per cycle,
//   set by the single read port of the prefix-sum and column memories.
// With more than one part, busy is high from the closing beat until the result; the receiver cannot stall.
// Reset (synchronous, rst_n low): part_count = 1, sequence empty, block idle.
module linear_partition_min_max_load
  import lpmml_pkg::*;
#(
  parameter int MAX_ITEMS = 64,
  parameter int MAX_PARTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [LEN_W-1:0]  in_length_value,
  input  logic              in_is_last,
  output logic              out_valid,
  output logic [LOAD_W-1:0] out_min_max_load,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  lpmml_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpmml_core #(
    .MAX_ITEMS (MAX_ITEMS),
    .MAX_PARTS (MAX_PARTS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .start            (start),
    .busy             (busy),
    .in_length_value  (in_length_value),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_min_max_load (out_min_max_load)
  );

endmodule

// File: sv/lpmml_chk.sv
`include "assert_macros.svh"

module lpmml_chk (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_is_last,
  input logic out_valid
);

  `LPMML_ASSERT_RST(a_rst_idle, !rst_n |=> (!busy && !out_valid), "not idle after reset")
  `LPMML_ASSERT(a_busy_cause, $rose(busy) |-> $past(start && in_is_last), "busy without closing beat")
  `LPMML_ASSERT(a_out_cause, out_valid |-> $past(busy || (start && in_is_last)), "stray result")
  `LPMML_ASSERT(a_busy_end, $fell(busy) |-> $past(out_valid), "busy ended without result")

endmodule

bind linear_partition_min_max_load lpmml_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_is_last (in_is_last),
  .out_valid  (out_valid)
);

// File: tb/tb.sv
module tb;
  import lpmml_pkg::*;

  localparam int MAX_ITEMS = 64;
  localparam int MAX_PARTS = 16;
  localparam int N_BEATS   = 850;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             last;
  } board_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [LEN_W-1:0]  in_length_value;
  logic              in_is_last;
  logic              out_valid;
  logic [LOAD_W-1:0] out_min_max_load;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  board_t            board_q[$];
  logic [LOAD_W-1:0] load_q[$];

  logic [PCNT_W-1:0] parts_reg;
  logic [LOAD_W-1:0] run_sums[MAX_ITEMS];
  int                run_n;

  logic beat_taken;
  logic idle_en;
  int   gap_left;
  int   beats_queued;
  int   seqs_queued;
  int   results_seen;
  int   fails;

  linear_partition_min_max_load #(
    .MAX_ITEMS(MAX_ITEMS),
    .MAX_PARTS(MAX_PARTS)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_length_value  (in_length_value),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_min_max_load (out_min_max_load),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // smallest largest part sum over the n stored prefix sums
  function automatic logic [LOAD_W-1:0] min_max_load_of(input int n, input int parts);
    logic [LOAD_W-1:0] prev_col[MAX_ITEMS];
    logic [LOAD_W-1:0] cur_col[MAX_ITEMS];
    logic [LOAD_W-1:0] best;
    logic [LOAD_W-1:0] rest;
    logic [LOAD_W-1:0] cand;
    for (int i = 0; i < n; i++) prev_col[i] = run_sums[i];
    for (int j = 2; j <= parts; j++) begin
      for (int i = 0; i < n; i++) begin
        best = '1;
        for (int l = 0; l <= i; l++) begin
          rest = run_sums[i] - run_sums[l];
          cand = (prev_col[l] > rest) ? prev_col[l] : rest;
          if (cand < best) best = cand;
        end
        cur_col[i] = best;
      end
      for (int i = 0; i < n; i++) prev_col[i] = cur_col[i];
    end
    return prev_col[n-1];
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r == 2) return LEN_W'($urandom_range(0, 15));
    return LEN_W'($urandom);
  endfunction

  // monitor: track accepted beats and register writes, check results
  always @(posedge clk) begin
    int parts;
    logic [LOAD_W-1:0] want;
    beat_taken = rst_n && start && !busy;
    if (!rst_n) begin
      parts_reg = PART_COUNT_RST;
      run_n     = 0;
    end else begin
      if (out_valid) begin
        if (load_q.size() == 0) begin
          $error("min_max_load: unexpected result %0d", out_min_max_load);
          fails++;
        end else begin
          want = load_q.pop_front();
          results_seen++;
          if (out_min_max_load !== want) begin
            $error("min_max_load: expected %0d, actual %0d", want, out_min_max_load);
            fails++;
          end
        end
      end
      if (beat_taken) begin
        if (run_n < MAX_ITEMS) begin
          run_sums[run_n] = (run_n == 0 ? '0 : run_sums[run_n-1]) + LOAD_W'(in_length_value);
          run_n++;
        end
        if (in_is_last) begin
          parts = parts_reg;
          if (parts == 0) parts = 1;
          if (parts > MAX_PARTS) parts = MAX_PARTS;
          load_q.push_back(min_max_load_of(run_n, parts));
          run_n = 0;
        end
      end
      if (psel && penable && pwrite && pready && paddr == ADDR_PART_COUNT)
        parts_reg = pwdata[PCNT_W-1:0];
    end
  end

  // driver: one beat at a time from board_q, random gaps between beats
  always @(negedge clk) begin
    board_t nxt;
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else if (!start || beat_taken) begin
      if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (board_q.size() != 0) begin
        nxt = board_q.pop_front();
        in_length_value <= nxt.len;
        in_is_last      <= nxt.last;
        start           <= 1'b1;
        gap_left        <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic push_board(input logic [LEN_W-1:0] len, input logic last);
    board_q.push_back('{len: len, last: last});
    beats_queued++;
    if (last) seqs_queued++;
  endtask

  task automatic queue_random_seq(input int n);
    for (int i = 0; i < n; i++) push_board(rand_len(), i == n - 1);
  endtask

  task automatic wait_idle();
    while (board_q.size() != 0 || start || load_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_parts(input logic [PCNT_W-1:0] value);
    logic [APB_DW-1:0] word;
    word = $urandom;
    word[PCNT_W-1:0] = value;
    wait_idle();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_PART_COUNT;
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int nseq;
    int r;
    int overflow_left;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_length_value = '0;
    in_is_last      = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    idle_en         = 1'b1;
    beats_queued    = 0;
    seqs_queued     = 0;
    results_seen    = 0;
    fails           = 0;
    overflow_left   = 3;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset part count, single beats, extremes
    push_board(16'hFFFF, 1'b1);
    push_board(16'h0000, 1'b1);
    push_board(16'd5, 1'b0);
    push_board(16'd0, 1'b0);
    push_board(16'd7, 1'b1);
    write_parts(5'd16);
    push_board(16'hFFFF, 1'b0);
    push_board(16'hFFFF, 1'b0);
    push_board(16'h0000, 1'b0);
    push_board(16'hFFFF, 1'b1);
    write_parts(5'd0);
    push_board(16'd10, 1'b0);
    push_board(16'd20, 1'b0);
    push_board(16'd30, 1'b1);
    write_parts(5'd2);
    for (int i = 1; i <= 5; i++) push_board(LEN_W'(i), i == 5);
    write_parts(5'd17);
    push_board(16'h0000, 1'b0);
    push_board(16'h0000, 1'b1);

    // full store at most parts, then overflowing sequences with a dropped closing beat
    write_parts(5'd16);
    for (int i = 0; i < MAX_ITEMS; i++) push_board(16'hFFFF, i == MAX_ITEMS - 1);
    write_parts(5'd31);
    queue_random_seq(70);
    write_parts(5'd3);
    queue_random_seq(MAX_ITEMS + 1);

    while (beats_queued < N_BEATS) begin
      r = $urandom_range(0, 9);
      if (r == 0)      write_parts(5'd0);
      else if (r == 1) write_parts(PCNT_W'($urandom_range(17, 31)));
      else             write_parts(PCNT_W'($urandom_range(1, 16)));
      idle_en = ($urandom_range(0, 3) != 0);
      nseq = $urandom_range(1, 5);
      for (int s = 0; s < nseq; s++) begin
        r = $urandom_range(0, 99);
        if (r < 3 && overflow_left > 0) begin
          overflow_left--;
          queue_random_seq($urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8));
        end else if (r < 10) begin
          queue_random_seq($urandom_range(13, 40));
        end else begin
          queue_random_seq($urandom_range(1, 12));
        end
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (load_q.size() != 0) begin
      $error("min_max_load: %0d results never arrived", load_q.size());
      fails++;
    end
    $display("tb: %0d beats in %0d sequences sent, %0d results checked", beats_queued,
             seqs_queued, results_seen);
    $display("tb: part counts from 0 to 31 used, store overflow and empty parts covered");
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #50000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/lpmml_pkg.sv
sv/lpmml_cfg.sv
sv/lpmml_core.sv
sv/linear_partition_min_max_load.sv
sv/lpmml_chk.sv
tb/tb.sv
